// ===== hw/rtl/mmsl_pkg.sv =====
package mmsl_pkg;

    // Field widths of one command and one result.
    localparam int unsigned REQ_W   = 17;
    localparam int unsigned LIM_W   = 16;
    localparam int unsigned STEP_W  = 16;
    localparam int unsigned DRV_W   = 18;
    localparam int unsigned QUO_W   = 16;
    localparam int unsigned MIX_W   = 19;
    localparam int unsigned PROD_W  = 26;
    localparam int unsigned IN_DW   = 72;
    localparam int unsigned OUT_DW  = 72;

    // Reset value of both slew step registers.
    localparam logic [STEP_W-1:0] STEP_RESET = 16'd51200;

    // Millivolts per percent of drive.
    localparam logic signed [PROD_W-1:0] MV_PER_PCT = 26'sd120;

    // Configuration register indexes.
    localparam logic CFG_RISE_STEP = 1'b0;
    localparam logic CFG_FALL_STEP = 1'b1;

    typedef enum logic [1:0] {
        OP_STOP  = 2'd0,
        OP_VOLT  = 2'd1,
        OP_CHAIN = 2'd2,
        OP_SWING = 2'd3
    } t_op;

    typedef enum logic [6:0] {
        S_IDLE = 7'b000_0001,
        S_PREP = 7'b000_0010,
        S_MUL  = 7'b000_0100,
        S_DIV  = 7'b000_1000,
        S_SLEW = 7'b001_0000,
        S_MIX  = 7'b010_0000,
        S_DONE = 7'b100_0000
    } t_state;

    // Magnitude of a signed request; the most negative value maps to 65536.
    function automatic logic [REQ_W-1:0] mag17(input logic signed [REQ_W-1:0] v);
        logic [REQ_W-1:0] m;
        m = v[REQ_W-1] ? REQ_W'(-v) : REQ_W'(v);
        return m;
    endfunction

endpackage

// ===== hw/rtl/mecanum_mix_slew_limiter_core.sv =====
// Mecanum drive mixer with magnitude normalisation and slew limiting.
// Commands enter on the slave stream: tuser carries the operation (stop,
// voltages, chained, swing) and tdata the x, y and turn requests and the
// magnitude limit. Each command produces exactly one result item on the
// master stream: four wheel drives in millivolts in tdata, and the brake and
// done flags in tuser. Two slew step registers are written through a plain
// write port; write them only while the block is idle (the block does not check).
//
// The block works on one item at a time and is not ready meanwhile. When the
// largest request exceeds the limit, a serial divider scales x, and y except
// for swing, by limit/largest, one quotient bit per cycle. Set-up accepts and
// compares the command; each scaled axis then takes one multiply step and the
// divide steps; the axes go through a shared slew unit (only x for swing) and
// the four wheels through a shared multiply-by-120 unit, and a hand-over step
// passes the result on. A stop goes from the compare straight to hand-over.
//
// Reset clears the stored axis values to zero and loads both step registers
// with their default. A finished result sits in an output register; the next
// command is accepted while it waits, and if the receiver still stalls when
// that command is done, the block holds it until the register is free.
module mecanum_mix_slew_limiter_core
    import mmsl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Configuration write port.
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [STEP_W-1:0] i_cfg_wdata,
    // Command stream.
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // req_x[16:0], req_y[33:17], req_turn[50:34], limit[66:51], zero pad.
    input  logic [IN_DW-1:0]  s_axis_tdata,
    // op[1:0].
    input  logic [1:0]        s_axis_tuser,
    // Result stream.
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // fl_mv[17:0], fr_mv[35:18], rl_mv[53:36], rr_mv[71:54] (front and rear
    // wheels, left and right).
    output logic [OUT_DW-1:0] m_axis_tdata,
    // brake[0], done_res[1].
    output logic [1:0]        m_axis_tuser
);

    t_state r_state, n_state;

    logic [STEP_W-1:0] r_rise, r_fall;

    // Command held for the duration of the work.
    t_op                      r_op;
    logic signed [REQ_W-1:0]  r_x, r_y, r_t;
    logic [LIM_W-1:0]         r_lim;
    logic [REQ_W-1:0]         r_big;

    // Axis values left by the last voltages or chained command.
    logic signed [REQ_W-1:0]  r_last_x, r_last_y, r_last_t;

    // Serial divider.
    logic                     r_ax;
    logic [3:0]               r_cnt;
    logic [REQ_W-1:0]         r_rem;
    logic [QUO_W-1:0]         r_dvd_lo;
    logic [QUO_W-1:0]         r_quo;
    logic                     r_neg;

    // Slew and mix sequencing index.
    logic [1:0]               r_idx;
    logic [DRV_W-1:0]         r_drv [4];

    // Output register.
    logic                     r_out_valid;
    logic [OUT_DW-1:0]        r_out_data;
    logic [1:0]               r_out_user;

    logic accept_in, out_free;

    assign s_axis_tready = (r_state == S_IDLE);
    assign accept_in     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !r_out_valid || m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    // Largest magnitude of the three requests.
    logic [REQ_W-1:0] mag_x, mag_y, mag_t, big;

    always_comb begin
        mag_x = mag17(r_x);
        mag_y = mag17(r_y);
        mag_t = mag17(r_t);
        big   = mag_t;
        if (mag_x > big) begin
            big = mag_x;
        end
        if (mag_y > big) begin
            big = mag_y;
        end
    end

    // Product |axis| * limit that feeds the divider.
    logic signed [REQ_W-1:0] div_axis;
    logic [32:0]             div_prod;

    assign div_axis = r_ax ? r_y : r_x;
    assign div_prod = 33'(mag17(div_axis)) * 33'(r_lim);

    // One restoring divide step per cycle.
    logic [REQ_W:0]          trial;
    logic                    q_bit;
    logic [REQ_W-1:0]        n_rem;
    logic [QUO_W-1:0]        n_quo;
    logic signed [REQ_W-1:0] div_res;

    always_comb begin
        trial   = {r_rem, r_dvd_lo[QUO_W-1]};
        q_bit   = (trial >= {1'b0, r_big});
        n_rem   = q_bit ? REQ_W'(trial - {1'b0, r_big}) : REQ_W'(trial);
        n_quo   = {r_quo[QUO_W-2:0], q_bit};
        div_res = r_neg ? REQ_W'(-{1'b0, n_quo}) : {1'b0, n_quo};
    end

    // Shared slew unit: moves one axis toward its request by at most a step.
    logic signed [REQ_W-1:0] sl_tgt, sl_cur, sl_res;
    logic [STEP_W-1:0]       sl_step;
    logic signed [MIX_W-1:0] sl_up, sl_dn, sl_tgt_w;

    always_comb begin
        case (r_idx)
            2'd0:    begin sl_tgt = r_x; sl_cur = r_last_x; end
            2'd1:    begin sl_tgt = r_y; sl_cur = r_last_y; end
            default: begin sl_tgt = r_t; sl_cur = r_last_t; end
        endcase
        sl_step  = (mag17(sl_cur) > mag17(sl_tgt)) ? r_fall : r_rise;
        sl_tgt_w = MIX_W'(sl_tgt);
        sl_up    = MIX_W'(sl_cur) + $signed({3'b000, sl_step});
        sl_dn    = MIX_W'(sl_cur) - $signed({3'b000, sl_step});
        if (sl_tgt_w > sl_up) begin
            sl_res = REQ_W'(sl_up);
        end else if (sl_tgt_w < sl_dn) begin
            sl_res = REQ_W'(sl_dn);
        end else begin
            sl_res = sl_tgt;
        end
    end

    // Shared mix unit: one wheel per cycle, scaled to millivolts and
    // truncated toward zero.
    logic signed [MIX_W-1:0]  mx_x, mx_y, mx_t, mix;
    logic signed [PROD_W-1:0] mv_prod, mv_adj;
    logic [DRV_W-1:0]         mv;

    always_comb begin
        mx_x = MIX_W'(r_x);
        mx_y = MIX_W'(r_y);
        mx_t = MIX_W'(r_t);
        if (r_op == OP_SWING) begin
            mix = r_idx[0] ? (mx_x <<< 1) : '0;
        end else begin
            // Sideways enters negatively on front left and back right, the
            // turn positively on the right-hand wheels.
            mix = mx_x
                + (((r_idx == 2'd0) || (r_idx == 2'd3)) ? -mx_y : mx_y)
                + (r_idx[0] ? mx_t : -mx_t);
        end
        mv_prod = PROD_W'(mix) * MV_PER_PCT;
        mv_adj  = mv_prod + (mv_prod[PROD_W-1] ? PROD_W'(255) : PROD_W'(0));
        mv      = mv_adj[PROD_W-1:8];
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_op == OP_STOP) begin
                    n_state = S_DONE;
                end else if (big > REQ_W'(r_lim)) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_SLEW;
                end
            end
            S_MUL: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (r_cnt == 4'd15) begin
                    n_state = (!r_ax && (r_op != OP_SWING)) ? S_MUL : S_SLEW;
                end
            end
            S_SLEW: begin
                if ((r_op == OP_SWING) || (r_idx == 2'd2)) begin
                    n_state = S_MIX;
                end
            end
            S_MIX: begin
                if (r_idx == 2'd3) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rise      <= STEP_RESET;
            r_fall      <= STEP_RESET;
            r_last_x    <= '0;
            r_last_y    <= '0;
            r_last_t    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_RISE_STEP) begin
                    r_rise <= i_cfg_wdata;
                end else begin
                    r_fall <= i_cfg_wdata;
                end
            end

            // A new result replaces the one leaving in the same cycle.
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_SLEW: begin
                    if (r_op != OP_SWING) begin
                        case (r_idx)
                            2'd0:    r_last_x <= sl_res;
                            2'd1:    r_last_y <= sl_res;
                            default: r_last_t <= sl_res;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept_in) begin
                    r_op  <= t_op'(s_axis_tuser);
                    r_x   <= s_axis_tdata[16:0];
                    r_y   <= s_axis_tdata[33:17];
                    r_t   <= s_axis_tdata[50:34];
                    r_lim <= s_axis_tdata[66:51];
                end
            end
            S_PREP: begin
                r_big <= big;
                r_ax  <= 1'b0;
                r_idx <= '0;
            end
            S_MUL: begin
                r_rem    <= div_prod[32:16];
                r_dvd_lo <= div_prod[15:0];
                r_neg    <= div_axis[REQ_W-1];
                r_quo    <= '0;
                r_cnt    <= '0;
            end
            S_DIV: begin
                r_rem    <= n_rem;
                r_dvd_lo <= {r_dvd_lo[QUO_W-2:0], 1'b0};
                r_quo    <= n_quo;
                r_cnt    <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    if (r_ax) begin
                        r_y <= div_res;
                    end else begin
                        r_x <= div_res;
                    end
                    r_ax <= 1'b1;
                end
            end
            S_SLEW: begin
                case (r_idx)
                    2'd0:    r_x <= sl_res;
                    2'd1:    r_y <= sl_res;
                    default: r_t <= sl_res;
                endcase
                r_idx <= (n_state == S_MIX) ? 2'd0 : r_idx + 2'd1;
            end
            S_MIX: begin
                r_drv[r_idx] <= mv;
                r_idx        <= r_idx + 2'd1;
            end
            S_DONE: begin
                if (out_free) begin
                    if (r_op == OP_STOP) begin
                        r_out_data <= '0;
                    end else begin
                        r_out_data <= {r_drv[3], r_drv[2], r_drv[1], r_drv[0]};
                    end
                    r_out_user <= {(r_op == OP_STOP) || (r_op == OP_CHAIN),
                                   (r_op == OP_STOP)};
                end
            end
            default: ;
        endcase
    end

`ifndef ASSERT_OFF
    // A braking result always carries zero drives and reports done.
    a_brake_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
        else $error("brake result with non-zero drives");

    a_brake_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser[0]) |-> m_axis_tuser[1])
        else $error("brake result without done");

    // A scaled axis never exceeds the limit in magnitude.
    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DIV) && (r_cnt == 4'd15)) |-> (n_quo <= r_lim))
        else $error("normalised axis exceeds limit");

    // Stored axis values only move while a command is being slewed.
    a_last_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_IDLE) && !s_axis_tvalid) |=>
            ($stable(r_last_x) && $stable(r_last_y) && $stable(r_last_t)))
        else $error("stored axis changed while idle");
`endif

endmodule
